// ----- src/swme_pkg.sv -----
// Package for the saturating weight matrix engine: sizes, commands, states.
package swme_pkg;
  localparam int unsigned MaxNodes = 16;
  localparam int unsigned IdxW = $clog2(MaxNodes);
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Depth = MaxNodes * MaxNodes;
  localparam logic [7:0] ResetMaxWeight = 8'd100;
  localparam logic [4:0] ResetNodeCount = 5'd16;
  localparam logic [7:0] ResetFill = 8'd50;

  localparam logic CfgMaxWeight = 1'b0;
  localparam logic CfgNodeCount = 1'b1;

  typedef enum logic [2:0] {
    CMD_SET  = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_READ = 3'd3,
    CMD_AVG  = 3'd4,
    CMD_ROW  = 3'd5,
    CMD_COL  = 3'd6,
    CMD_FILL = 3'd7
  } cmd_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_RD    = 8'b00000010,
    ST_UPD   = 8'b00000100,
    ST_SCAN  = 8'b00001000,
    ST_DIV   = 8'b00010000,
    ST_FILL  = 8'b00100000,
    ST_CLEAR = 8'b01000000,
    ST_MUL   = 8'b10000000
  } state_t;
endpackage

// ----- src/saturating_weight_matrix_engine_unit.sv -----
// Saturating weight matrix engine: 16x16 weight store with a command sequencer.
// Set/add/read pass through the read and update states, multiply adds a multiply
// state; a list scan reads one stored entry per cycle through the single memory
// port; average is a scan followed by a 20-step divider; fill writes every entry;
// index/count errors are answered from idle. One command at a time; busy drops in the cycle
// the last result is on the ports, so the next command is taken at that edge.
// Reset (sync, active high) runs a pass writing 50 to all 256 entries; busy stays high.
module saturating_weight_matrix_engine_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  cmd,
  input  logic [3:0]                  from_node,
  input  logic [3:0]                  to_node,
  input  logic [7:0]                  new_weight,
  input  logic signed [8:0]           addend,
  input  logic [15:0]                 factor,
  input  logic [7:0]                  threshold,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [7:0]                  cfg_data,
  output logic                        strobe,
  output logic [7:0]                  weight_out,
  output logic [3:0]                  node_id,
  output logic [15:0]                 average_out,
  output logic                        found,
  output logic                        last,
  output logic                        error
);
  import swme_pkg::*;

  // configuration registers
  logic [7:0] max_weight;
  logic [4:0] node_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_weight <= ResetMaxWeight;
      node_count <= ResetNodeCount;
    end else if (cfg_we) begin
      if (cfg_index == CfgMaxWeight) max_weight <= cfg_data;
      else node_count <= cfg_data[4:0];
    end
  end

  // effective node count, capped at the store size
  logic [4:0] n_eff;
  assign n_eff = (node_count > 5'(MaxNodes)) ? 5'(MaxNodes) : node_count;

  // weight store: one write port, one registered read port
  logic [7:0]       mem [Depth];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_q;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  // captured transaction
  state_t       state;
  cmd_t         op;
  logic [3:0]   fr, to;
  logic [7:0]   nw, th;
  logic signed [8:0] add_r;
  logic [15:0]  fac;
  logic [AddrW:0] cnt;      // sweep / scan counter (wide enough for Depth)
  logic         rd_pend;    // scan: memory data for index idx_q valid
  logic [3:0]   idx_q;
  logic         hold_v;     // list: a pending match waiting for output
  logic [3:0]   hold_id;
  logic [11:0]  sum;
  logic [23:0]  prod;
  // divider
  logic [19:0]  rem;
  logic [19:0]  dividend;
  logic [15:0]  quo;
  logic [4:0]   dcnt;

  logic in_range;
  assign in_range = ({1'b0, from_node} < n_eff) && ({1'b0, to_node} < n_eff);

  assign busy = (state != ST_IDLE);

  // scan address: row list reads (fr, i), column list/average reads (i, fr)
  logic [3:0] scan_i;
  assign scan_i = cnt[IdxW-1:0];

  logic signed [9:0] add_sum;
  logic [8:0]        add_clamp;
  assign add_sum = $signed({2'b00, mem_q}) + 10'(add_r);
  assign add_clamp = add_sum[9] ? 9'd0 : add_sum[8:0];

  logic [20:0] trial;
  assign trial = {rem, dividend[19]} - {16'd0, n_eff - 5'd1};

  // updated weight for set/add/multiply, written back in ST_UPD
  logic [7:0] upd_w;
  always_comb begin
    upd_w = mem_q;
    case (op)
      CMD_SET: upd_w = nw;
      CMD_ADD: upd_w = (add_clamp > {1'b0, max_weight}) ? max_weight : add_clamp[7:0];
      CMD_MUL: upd_w = (prod[23:8] > {8'd0, max_weight}) ? max_weight : prod[15:8];
      default: upd_w = mem_q;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = {fr, to};
    mem_wdata = upd_w;
    mem_raddr = {fr, to};
    if (state == ST_SCAN) mem_raddr = (op == CMD_ROW) ? {fr, scan_i} : {scan_i, fr};
    if (state == ST_UPD && op != CMD_READ) mem_we = 1'b1;
    if (state == ST_FILL || state == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = cnt[AddrW-1:0];
      mem_wdata = (state == ST_CLEAR) ? ResetFill : {1'b0, max_weight[7:1]};
    end
  end

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    weight_out <= '0; node_id <= '0; average_out <= '0;
    found <= 1'b0; last <= 1'b0; error <= 1'b0;
    if (rst) begin
      state <= ST_CLEAR;
      cnt <= '0;
    end else begin
      case (state)
        ST_CLEAR, ST_FILL: begin
          cnt <= cnt + 1'b1;
          if (cnt[AddrW-1:0] == AddrW'(Depth - 1)) begin
            if (state == ST_FILL) begin
              strobe <= 1'b1; last <= 1'b1;
              weight_out <= {1'b0, max_weight[7:1]};
            end
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            op <= cmd_t'(cmd); fr <= from_node; to <= to_node;
            nw <= new_weight; add_r <= addend; fac <= factor; th <= threshold;
            cnt <= '0; rd_pend <= 1'b0; hold_v <= 1'b0;
            sum <= '0;
            if (cmd_t'(cmd) == CMD_FILL) state <= ST_FILL;
            else if (cmd <= 3'(CMD_READ)) begin
              if (in_range) state <= ST_RD;
              else begin
                strobe <= 1'b1; last <= 1'b1; error <= 1'b1;
              end
            end else if (({1'b0, from_node} >= n_eff) ||
                         (cmd_t'(cmd) == CMD_AVG && n_eff <= 5'd1)) begin
              strobe <= 1'b1; last <= 1'b1; error <= 1'b1;
            end else state <= ST_SCAN;
          end
        end
        ST_RD: state <= (op == CMD_MUL) ? ST_MUL : ST_UPD;
        ST_MUL: begin
          prod <= mem_q * fac;
          state <= ST_UPD;
        end
        ST_UPD: begin
          // store write-back (not for read) happens this cycle through the memory port
          state <= ST_IDLE;
          strobe <= 1'b1; last <= 1'b1; weight_out <= upd_w;
        end
        ST_SCAN: begin
          // issue read for cnt, consume data for idx_q
          rd_pend <= (cnt < {1'b0, n_eff});
          idx_q <= scan_i;
          if (cnt < {1'b0, n_eff}) cnt <= cnt + 1'b1;
          if (rd_pend && idx_q != fr) begin
            if (op == CMD_AVG) sum <= sum + 12'(mem_q);
            else if (mem_q > th) begin
              if (hold_v) begin
                strobe <= 1'b1; found <= 1'b1; node_id <= hold_id;
              end
              hold_v <= 1'b1; hold_id <= idx_q;
            end
          end
          if (!rd_pend && cnt >= {1'b0, n_eff}) begin
            if (op == CMD_AVG) begin
              dividend <= {sum, 8'd0};
              rem <= '0; quo <= '0; dcnt <= '0;
              state <= ST_DIV;
            end else begin
              strobe <= 1'b1; last <= 1'b1;
              found <= hold_v; node_id <= hold_v ? hold_id : 4'd0;
              state <= ST_IDLE;
            end
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          dividend <= {dividend[18:0], 1'b0};
          if (!trial[20]) begin
            rem <= trial[19:0]; quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= {rem[18:0], dividend[19]}; quo <= {quo[14:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 5'd19) begin
            strobe <= 1'b1; last <= 1'b1;
            average_out <= !trial[20] ? {quo[14:0], 1'b1} : {quo[14:0], 1'b0};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_more_follows_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy) else $error("list result without a scan running");
  a_busy_no_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> busy) else $error("divider active while idle");
`endif
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the saturating weight matrix engine: scoreboard, directed and random commands.
module tb_top;
  import swme_pkg::*;

  // Expected result of one transaction on the result side.
  typedef struct {
    logic [7:0]  weight;
    logic [3:0]  id;
    logic [15:0] avg;
    logic        fnd;
    logic        lst;
    logic        err;
  } weight_result_t;

  // Scoreboard: keeps a shadow of the weight store and registers, predicts
  // results per accepted command and checks results in order.
  class weight_scoreboard;
    logic [7:0] shadow_matrix [MaxNodes*MaxNodes];
    logic [7:0] ceiling;
    logic [4:0] nodes;
    weight_result_t pending [$];
    int errors;

    function new();
      ceiling = ResetMaxWeight;
      nodes = ResetNodeCount;
      errors = 0;
      foreach (shadow_matrix[i]) shadow_matrix[i] = ResetFill;
    endfunction

    function void write_reg(logic idx, logic [7:0] v);
      if (idx == CfgMaxWeight) ceiling = v;
      else nodes = v[4:0];
    endfunction

    function void push(logic [7:0] w, logic [3:0] id, logic [15:0] a,
                       logic f, logic l, logic e);
      weight_result_t r;
      r.weight = w; r.id = id; r.avg = a; r.fnd = f; r.lst = l; r.err = e;
      pending.push_back(r);
    endfunction

    function void note_command(cmd_t c, logic [3:0] fr, logic [3:0] to,
                               logic [7:0] nw, logic signed [8:0] ad,
                               logic [15:0] fac, logic [7:0] th);
      int n, s, idx, cnt, sum;
      logic [7:0] w;
      longint p;
      n = (nodes > MaxNodes) ? MaxNodes : nodes;
      if (c == CMD_FILL) begin
        foreach (shadow_matrix[i]) shadow_matrix[i] = ceiling >> 1;
        push(ceiling >> 1, 0, 0, 0, 1, 0);
        return;
      end
      if (c inside {CMD_SET, CMD_ADD, CMD_MUL, CMD_READ}) begin
        if (fr >= n || to >= n) begin
          push(0, 0, 0, 0, 1, 1);
          return;
        end
        idx = fr * MaxNodes + to;
        w = shadow_matrix[idx];
        case (c)
          CMD_SET: w = nw;
          CMD_ADD: begin
            s = int'(w) + int'(ad);
            if (s < 0) s = 0;
            w = (s > ceiling) ? ceiling : s[7:0];
          end
          CMD_MUL: begin
            p = (longint'(w) * longint'(fac)) >> 8;
            w = (p > ceiling) ? ceiling : p[7:0];
          end
          default: ;
        endcase
        shadow_matrix[idx] = w;
        push(w, 0, 0, 0, 1, 0);
        return;
      end
      if (fr >= n) begin
        push(0, 0, 0, 0, 1, 1);
        return;
      end
      if (c == CMD_AVG) begin
        if (n <= 1) begin
          push(0, 0, 0, 0, 1, 1);
          return;
        end
        sum = 0;
        for (int i = 0; i < n; i++)
          if (i != fr) sum += shadow_matrix[i * MaxNodes + fr];
        push(0, 0, 16'((sum << 8) / (n - 1)), 0, 1, 0);
        return;
      end
      cnt = 0;
      for (int i = 0; i < n; i++) begin
        if (i == fr) continue;
        w = (c == CMD_ROW) ? shadow_matrix[fr * MaxNodes + i]
                           : shadow_matrix[i * MaxNodes + fr];
        if (w > th) begin
          push(0, i[3:0], 0, 1, 0, 0);
          cnt++;
        end
      end
      if (cnt == 0) push(0, 0, 0, 0, 1, 0);
      else pending[$].lst = 1;
    endfunction

    function void check(logic [7:0] w, logic [3:0] id, logic [15:0] a,
                        logic f, logic l, logic e);
      weight_result_t x;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      x = pending.pop_front();
      if (w !== x.weight) begin
        $error("weight_out exp %0d got %0d", x.weight, w); errors++;
      end
      if (id !== x.id) begin
        $error("node_id exp %0d got %0d", x.id, id); errors++;
      end
      if (a !== x.avg) begin
        $error("average_out exp %0d got %0d", x.avg, a); errors++;
      end
      if (f !== x.fnd) begin
        $error("found exp %0d got %0d", x.fnd, f); errors++;
      end
      if (l !== x.lst) begin
        $error("last exp %0d got %0d", x.lst, l); errors++;
      end
      if (e !== x.err) begin
        $error("error exp %0d got %0d", x.err, e); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0, busy;
  logic [2:0] cmd = 0;
  logic [3:0] from_node = 0, to_node = 0;
  logic [7:0] new_weight = 0;
  logic signed [8:0] addend = 0;
  logic [15:0] factor = 0;
  logic [7:0] threshold = 0;
  logic cfg_we = 0, cfg_index = 0;
  logic [7:0] cfg_data = 0;
  logic strobe, found, last, error;
  logic [7:0] weight_out;
  logic [3:0] node_id;
  logic [15:0] average_out;

  weight_scoreboard sb;
  int send_idle_pct = 0;  // percent of cycles the sender holds off
  longint cycle_count = 0;
  localparam longint CycleLimit = 2000000;

  saturating_weight_matrix_engine_unit dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Result side never stalls; sample every strobe at the edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && strobe) sb.check(weight_out, node_id, average_out, found, last, error);
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // One transaction: optional idle gap, then hold start until accepted.
  // start stays high after acceptance; the next task call drives it.
  task automatic send_cmd(cmd_t c, logic [3:0] fr, logic [3:0] to, logic [7:0] nw,
                          logic signed [8:0] ad, logic [15:0] fac, logic [7:0] th);
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    start <= 1; cmd <= c; from_node <= fr; to_node <= to;
    new_weight <= nw; addend <= ad; factor <= fac; threshold <= th;
    do @(posedge clk); while (busy);
    // accepted at this edge
    sb.note_command(c, fr, to, nw, ad, fac, th);
  endtask

  // Wait until all results are in and the engine is no longer busy.
  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] v);
    drain();
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
  endtask

  task automatic random_cmd(int n);
    cmd_t c;
    logic [3:0] fr, to;
    c = cmd_t'($urandom_range(7));
    // fill is slow and wipes the store: keep it rare
    if (c == CMD_FILL && $urandom_range(9) != 0) c = CMD_SET;
    fr = 4'(($urandom_range(9) == 0 || n == 0) ? $urandom_range(15)
                                               : $urandom_range(n - 1));
    to = 4'(($urandom_range(9) == 0 || n == 0) ? $urandom_range(15)
                                               : $urandom_range(n - 1));
    send_cmd(c, fr, to, 8'($urandom_range(255)), 9'($urandom_range(510) - 255),
             16'($urandom_range(65535)), 8'($urandom_range(255)));
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed: every command, index edges, saturation both ways.
    send_cmd(CMD_READ, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_SET, 15, 15, 255, 0, 0, 0);
    send_cmd(CMD_ADD, 15, 15, 0, 9'sd1, 0, 0);      // stored above ceiling
    send_cmd(CMD_SET, 0, 1, 0, 0, 0, 0);
    send_cmd(CMD_ADD, 0, 1, 0, -9'sd255, 0, 0);     // clamp at zero
    send_cmd(CMD_ADD, 0, 1, 0, 9'sd255, 0, 0);      // clamp at ceiling
    send_cmd(CMD_MUL, 0, 1, 0, 0, 16'hFFFF, 0);
    send_cmd(CMD_MUL, 0, 1, 0, 0, 16'h0080, 0);
    send_cmd(CMD_MUL, 0, 1, 0, 0, 16'h0000, 0);
    send_cmd(CMD_AVG, 1, 0, 0, 0, 0, 0);
    send_cmd(CMD_ROW, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_COL, 15, 0, 0, 0, 0, 255);         // nothing matches
    send_cmd(CMD_COL, 1, 0, 0, 0, 0, 0);
    send_cmd(CMD_FILL, 0, 0, 0, 0, 0, 0);
    write_cfg(CfgNodeCount, 8'd1);
    send_cmd(CMD_AVG, 0, 0, 0, 0, 0, 0);            // average with one node
    send_cmd(CMD_SET, 1, 0, 7, 0, 0, 0);            // out of range
    send_cmd(CMD_ROW, 1, 0, 0, 0, 0, 0);
    write_cfg(CfgNodeCount, 8'd0);
    send_cmd(CMD_READ, 0, 0, 0, 0, 0, 0);           // zero nodes
    write_cfg(CfgNodeCount, 8'd31);
    write_cfg(CfgMaxWeight, 8'd255);
    send_cmd(CMD_FILL, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_AVG, 15, 0, 0, 0, 0, 0);
    write_cfg(CfgMaxWeight, 8'd0);
    send_cmd(CMD_ADD, 2, 3, 0, 9'sd100, 0, 0);

    // Random phases with varying registers and sender idling.
    for (int ph = 0; ph < 7; ph++) begin
      int n;
      write_cfg(CfgMaxWeight, (ph == 0) ? 8'd255 : 8'($urandom_range(255)));
      write_cfg(CfgNodeCount, (ph == 1) ? 8'd16 : (ph == 2) ? 8'd2
                                                 : 8'($urandom_range(31)));
      n = (sb.nodes > MaxNodes) ? MaxNodes : sb.nodes;
      send_idle_pct = (ph % 4 == 1) ? 66 : (ph % 4 == 3) ? 31 : 0;
      for (int k = 0; k < 40; k++) begin
        random_cmd(n);
        if (k == 20) drain();   // sender pauses until all results are in
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule
